FILE: rtl/core/brce_pkg.sv
// -----------------------------------------------------------------------------
// Bit range copy engine package
// Shared types, field widths and default sizes for the copy engine.
// -----------------------------------------------------------------------------
package brce_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int DATA_W = 64;
   localparam int IDX_W  = 6;
   localparam int POS_W  = 12;
   localparam int CNT_W  = 13;

   // Default store geometry.
   localparam int DEF_WORD_BITS   = 64;
   localparam int DEF_STORE_WORDS = 64;

   typedef enum logic [1:0] {
      OP_WRITE_SRC = 2'd0,
      OP_WRITE_DST = 2'd1,
      OP_COPY      = 2'd2,
      OP_READ      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_COPY,
      ST_READ,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      op_type              opcode;
      logic [IDX_W-1:0]    word_index;
      logic [DATA_W-1:0]   word_data;
      logic [POS_W-1:0]    dst_bit;
      logic [POS_W-1:0]    src_bit;
      logic [CNT_W-1:0]    bit_count;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic                range_error;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic write_src;
      logic write_dst;
      logic read_issue;
      logic read_capture;
      logic div_step;
      logic copy_issue;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic chk_skip;
      logic last_word;
   } status_type;

endpackage

FILE: rtl/core/brce_ctrl.sv
// -----------------------------------------------------------------------------
// Bit range copy engine controller
// Sequences each transaction: writes, reads, and the split and word walk of a
// copy. Drives the datapath through a command struct.
// -----------------------------------------------------------------------------
module brce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  brce_pkg::op_type      opcode,
   input  brce_pkg::status_type  status,
   output brce_pkg::cmd_type     cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import brce_pkg::*;

   state_type         state_ff;
   state_type         state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (opcode)
                  OP_WRITE_SRC: begin
                     cmd.write_src = 1'b1;
                     state_in      = ST_RESPOND;
                  end
                  OP_WRITE_DST: begin
                     cmd.write_dst = 1'b1;
                     state_in      = ST_RESPOND;
                  end
                  OP_READ: begin
                     cmd.read_issue = 1'b1;
                     state_in       = ST_READ;
                  end
                  OP_COPY: begin
                     state_in = status.chk_skip ? ST_RESPOND : ST_DIVIDE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            state_in     = ST_COPY;
         end
         ST_COPY: begin
            cmd.copy_issue = 1'b1;
            if (status.last_word) begin
               state_in = ST_RESPOND;
            end
         end
         ST_READ: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESPOND);

endmodule

FILE: rtl/core/brce_datapath.sv
// -----------------------------------------------------------------------------
// Bit range copy engine datapath
// Holds both stores, splits bit positions into word and offset, and merges
// one destination word per cycle from two source words during a copy.
// -----------------------------------------------------------------------------
module brce_datapath #(
   parameter int WORD_BITS   = brce_pkg::DEF_WORD_BITS,
   parameter int STORE_WORDS = brce_pkg::DEF_STORE_WORDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  brce_pkg::req_type     req_payload,
   input  brce_pkg::cmd_type     cmd,
   output brce_pkg::status_type  status,
   output brce_pkg::rsp_type     rsp_payload
);
   import brce_pkg::*;

   localparam int OFFW   = $clog2(WORD_BITS);
   localparam int NW     = OFFW + 1;
   localparam int AW     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int TOTW   = 20;
   localparam int TOTAL  = WORD_BITS * STORE_WORDS;

   // Reciprocal of the word size, exact for every bit position.
   localparam int RSH    = POS_W + OFFW;
   localparam int RCP_W  = POS_W + 1;
   localparam int PRW    = POS_W + RCP_W;
   localparam int RECIP  = ((1 << RSH) + WORD_BITS - 1) / WORD_BITS;

   // Stores.
   logic [WORD_BITS-1:0] source_store_ff [STORE_WORDS];
   logic [WORD_BITS-1:0] dest_store_ff   [STORE_WORDS];
   logic [WORD_BITS-1:0] src_lo_rd_ff;
   logic [WORD_BITS-1:0] src_hi_rd_ff;
   logic [WORD_BITS-1:0] dst_rd_ff;

   // Position registers: bit position during the split, then word pointer.
   logic [POS_W-1:0]     dnum_ff, dnum_in;
   logic [POS_W-1:0]     snum_ff, snum_in;
   logic [OFFW-1:0]      drem_ff, drem_in;
   logic [OFFW-1:0]      srem_ff, srem_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;

   // Merge stage registers.
   logic                 p_valid_ff;
   logic [AW-1:0]        p_addr_ff;
   logic [WORD_BITS-1:0] p_mask_ff;
   logic [OFFW-1:0]      p_doff_ff;
   logic [OFFW-1:0]      p_soff_ff;

   // Result registers.
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 err_ff;
   logic                 idx_ok_ff;

   // Request checks.
   logic                 idx_ok;
   logic [AW-1:0]        req_addr;
   logic                 cnt_zero;
   logic                 over;
   logic [TOTW-1:0]      dst_end;
   logic [TOTW-1:0]      src_end;

   assign idx_ok   = (CNT_W'(req_payload.word_index) < CNT_W'(STORE_WORDS));
   assign req_addr = AW'(req_payload.word_index);
   assign cnt_zero = (req_payload.bit_count == '0);
   assign dst_end  = TOTW'(req_payload.dst_bit) + TOTW'(req_payload.bit_count);
   assign src_end  = TOTW'(req_payload.src_bit) + TOTW'(req_payload.bit_count);
   assign over     = (dst_end > TOTW'(TOTAL)) || (src_end > TOTW'(TOTAL));

   assign status.chk_skip = cnt_zero || over;

   // Split each position into word and offset by reciprocal multiplication.
   logic [PRW-1:0]   d_prod, s_prod;
   logic [POS_W-1:0] d_quo, s_quo;
   logic [POS_W-1:0] d_left, s_left;

   assign d_prod = PRW'(dnum_ff) * PRW'(RECIP);
   assign s_prod = PRW'(snum_ff) * PRW'(RECIP);
   assign d_quo  = POS_W'(d_prod >> RSH);
   assign s_quo  = POS_W'(s_prod >> RSH);
   assign d_left = dnum_ff - d_quo * POS_W'(WORD_BITS);
   assign s_left = snum_ff - s_quo * POS_W'(WORD_BITS);

   // Word walk: bits that fall into the current destination word.
   logic [NW-1:0]        room;
   logic                 last;
   logic [NW-1:0]        nbits;
   logic [WORD_BITS-1:0] lo_mask;
   logic [WORD_BITS-1:0] mask;
   logic [NW-1:0]        ssum;
   logic                 swrap;
   logic [NW-1:0]        sdiff;

   assign room    = NW'(WORD_BITS) - NW'(drem_ff);
   assign last    = (remain_ff <= CNT_W'(room));
   assign nbits   = last ? NW'(remain_ff) : room;
   assign lo_mask = {WORD_BITS{1'b1}} >> (NW'(WORD_BITS) - nbits);
   assign mask    = lo_mask << drem_ff;
   assign ssum    = NW'(srem_ff) + nbits;
   assign swrap   = (ssum >= NW'(WORD_BITS));
   assign sdiff   = ssum - NW'(WORD_BITS);

   assign status.last_word = last;

   // Next values of the position registers.
   always_comb begin
      dnum_in   = dnum_ff;
      snum_in   = snum_ff;
      drem_in   = drem_ff;
      srem_in   = srem_ff;
      remain_in = remain_ff;
      if (cmd.load) begin
         dnum_in   = req_payload.dst_bit;
         snum_in   = req_payload.src_bit;
         drem_in   = '0;
         srem_in   = '0;
         remain_in = req_payload.bit_count;
      end else if (cmd.div_step) begin
         dnum_in = d_quo;
         snum_in = s_quo;
         drem_in = d_left[OFFW-1:0];
         srem_in = s_left[OFFW-1:0];
      end else if (cmd.copy_issue) begin
         dnum_in   = dnum_ff + POS_W'(1);
         drem_in   = '0;
         snum_in   = snum_ff + POS_W'(swrap);
         srem_in   = swrap ? sdiff[OFFW-1:0] : ssum[OFFW-1:0];
         remain_in = remain_ff - CNT_W'(nbits);
      end
   end

   always_ff @(posedge clock) begin
      dnum_ff   <= dnum_in;
      snum_ff   <= snum_in;
      drem_ff   <= drem_in;
      srem_ff   <= srem_in;
      remain_ff <= remain_in;
   end

   // Merge stage control and payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= cmd.copy_issue;
      end
   end

   always_ff @(posedge clock) begin
      p_addr_ff <= dnum_ff[AW-1:0];
      p_mask_ff <= mask;
      p_doff_ff <= drem_ff;
      p_soff_ff <= srem_ff;
   end

   // Source read addresses; the upper word falls back when past the store.
   logic [POS_W:0]  hi_ptr;
   logic [AW-1:0]   src_lo_addr;
   logic [AW-1:0]   src_hi_addr;

   assign hi_ptr      = (POS_W + 1)'(snum_ff) + (POS_W + 1)'(1);
   assign src_lo_addr = snum_ff[AW-1:0];
   assign src_hi_addr = (hi_ptr < (POS_W + 1)'(STORE_WORDS)) ? hi_ptr[AW-1:0] : src_lo_addr;

   // Merge of the aligned source bits into the old destination word.
   logic [2*WORD_BITS-1:0] pair;
   logic [2*WORD_BITS-1:0] aligned;
   logic [WORD_BITS-1:0]   placed;
   logic [WORD_BITS-1:0]   merged;

   assign pair    = {src_hi_rd_ff, src_lo_rd_ff};
   assign aligned = pair >> p_soff_ff;
   assign placed  = aligned[WORD_BITS-1:0] << p_doff_ff;
   assign merged  = (dst_rd_ff & ~p_mask_ff) | (placed & p_mask_ff);

   // Source store: host writes, two registered reads.
   logic src_we;
   assign src_we = cmd.write_src && idx_ok;

   always_ff @(posedge clock) begin
      if (src_we) begin
         source_store_ff[req_addr] <= req_payload.word_data[WORD_BITS-1:0];
      end
      src_lo_rd_ff <= source_store_ff[src_lo_addr];
      src_hi_rd_ff <= source_store_ff[src_hi_addr];
   end

   // Destination store: host or merge writes, one registered read.
   logic                 dst_we;
   logic [AW-1:0]        dst_wa;
   logic [WORD_BITS-1:0] dst_wd;
   logic [AW-1:0]        dst_ra;

   assign dst_we = p_valid_ff || (cmd.write_dst && idx_ok);
   assign dst_wa = p_valid_ff ? p_addr_ff : req_addr;
   assign dst_wd = p_valid_ff ? merged : req_payload.word_data[WORD_BITS-1:0];
   assign dst_ra = cmd.read_issue ? req_addr : dnum_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (dst_we) begin
         dest_store_ff[dst_wa] <= dst_wd;
      end
      dst_rd_ff <= dest_store_ff[dst_ra];
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_data_ff <= '0;
         err_ff     <= (req_payload.opcode == OP_COPY) && !cnt_zero && over;
         idx_ok_ff  <= idx_ok;
      end else if (cmd.read_capture) begin
         rd_data_ff <= idx_ok_ff ? dst_rd_ff : '0;
      end
   end

   assign rsp_payload.read_data   = DATA_W'(rd_data_ff);
   assign rsp_payload.range_error = err_ff;

endmodule

FILE: rtl/core/bit_range_copy_engine_top.sv
// -----------------------------------------------------------------------------
// Bit range copy engine top level
// Word writes on both stores, word reads from the destination store, and bit
// range copies from source to destination, one transaction at a time.
// -----------------------------------------------------------------------------
// A write strobes in the cycle after acceptance; a read passes through a read
// state first. A copy splits the bit positions, then walks the destination
// words touched (up to STORE_WORDS), merging one word per cycle. A refused or
// empty copy strobes in the cycle after acceptance. Busy falls the cycle after
// the strobe, when the next transaction can be accepted.
// Synchronous reset returns the controller to idle; stores are not cleared.
module bit_range_copy_engine_top #(
   parameter int WORD_BITS   = brce_pkg::DEF_WORD_BITS,
   parameter int STORE_WORDS = brce_pkg::DEF_STORE_WORDS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  brce_pkg::req_type  req_payload,
   output logic               rsp_valid,
   output brce_pkg::rsp_type  rsp_payload
);
   import brce_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Transaction sequencing.
   brce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (req_payload.opcode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Stores and word merge.
   brce_datapath #(
      .WORD_BITS   (WORD_BITS),
      .STORE_WORDS (STORE_WORDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/core/brce_checker.sv
// -----------------------------------------------------------------------------
// Bit range copy engine port checker
// Watches the top level's ports for handshake and timing rules.
// -----------------------------------------------------------------------------
module brce_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input brce_pkg::req_type  req_payload,
   input logic               rsp_valid,
   input brce_pkg::rsp_type  rsp_payload
);
   import brce_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // The block is idle and quiet on the cycle after a reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   // An accepted transaction makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

   // A result ends the transaction: the block is idle next cycle.
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("block stayed busy after its result");

   // A write answers on the next cycle with an empty, error-free result.
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_payload.opcode == OP_WRITE_SRC ||
                  req_payload.opcode == OP_WRITE_DST))
      |=> (rsp_valid && rsp_payload.read_data == '0 && !rsp_payload.range_error))
      else $error("write result wrong or late");

   // A read answers after passing through the read state and never flags an error.
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.opcode == OP_READ)
      |=> ##1 (rsp_valid && !rsp_payload.range_error))
      else $error("read result wrong or late");

endmodule

bind bit_range_copy_engine_top brce_checker u_brce_checker (.*);
